@@ rtl/sfxseq_pkg.sv @@
package sfxseq_pkg;

  typedef enum logic [1:0] {
    OP_PLAY  = 2'd0,
    OP_ENQ   = 2'd1,
    OP_TICK  = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  localparam int unsigned FREQ_W      = 15;
  localparam int unsigned LEN_W       = 15;
  localparam int unsigned NOTE_W      = FREQ_W + LEN_W;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned EFFECT_W    = 4;
  localparam int unsigned QCOUNT_W    = 4;
  localparam int unsigned NUM_EFFECTS = 12;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [LEN_W-1:0]  len;
  } note_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic clear_all;
    logic push_rom;
    logic push_in;
    logic tick_check;
    logic tick_apply;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_t  op;
    logic effect_known;
    logic rom_last;
  } status_t;

  function automatic note_t mk_note(input int unsigned f, input int unsigned l);
    note_t n;
    n.freq = FREQ_W'(f);
    n.len  = LEN_W'(l);
    return n;
  endfunction

  // Index of the final note of each effect
  function automatic logic [1:0] effect_last_idx(input logic [EFFECT_W-1:0] eff);
    logic [1:0] r;
    case (eff)
      4'd1, 4'd3, 4'd11: r = 2'd2;
      4'd6, 4'd9:        r = 2'd1;
      4'd10:             r = 2'd3;
      default:           r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic note_t effect_note(input logic [EFFECT_W-1:0] eff,
                                        input logic [1:0] idx);
    note_t n;
    n = mk_note(0, 0);
    case ({eff, idx})
      {4'd0, 2'd0}:  n = mk_note(440, 30);
      {4'd1, 2'd0}:  n = mk_note(800, 50);
      {4'd1, 2'd1}:  n = mk_note(1000, 50);
      {4'd1, 2'd2}:  n = mk_note(1200, 50);
      {4'd2, 2'd0}:  n = mk_note(880, 60);
      {4'd3, 2'd0}:  n = mk_note(392, 100);
      {4'd3, 2'd1}:  n = mk_note(330, 100);
      {4'd3, 2'd2}:  n = mk_note(262, 150);
      {4'd4, 2'd0}:  n = mk_note(600, 40);
      {4'd5, 2'd0}:  n = mk_note(400, 40);
      {4'd6, 2'd0}:  n = mk_note(523, 80);
      {4'd6, 2'd1}:  n = mk_note(659, 80);
      {4'd7, 2'd0}:  n = mk_note(1000, 30);
      {4'd8, 2'd0}:  n = mk_note(700, 40);
      {4'd9, 2'd0}:  n = mk_note(440, 100);
      {4'd9, 2'd1}:  n = mk_note(330, 100);
      {4'd10, 2'd0}: n = mk_note(392, 150);
      {4'd10, 2'd1}: n = mk_note(330, 150);
      {4'd10, 2'd2}: n = mk_note(294, 150);
      {4'd10, 2'd3}: n = mk_note(262, 300);
      {4'd11, 2'd0}: n = mk_note(523, 80);
      {4'd11, 2'd1}: n = mk_note(659, 80);
      {4'd11, 2'd2}: n = mk_note(784, 120);
      default:       n = mk_note(0, 0);
    endcase
    return n;
  endfunction

endpackage

@@ rtl/sfxseq_ctrl.sv @@
module sfxseq_ctrl
  import sfxseq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_LOAD   = 5'b00100,
    S_TICK   = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.op)
          OP_PLAY: begin
            cmd.clear_all = 1'b1;
            state_next    = status.effect_known ? S_LOAD : S_FIN;
          end
          OP_ENQ: begin
            cmd.push_in = 1'b1;
            state_next  = S_FIN;
          end
          OP_TICK: begin
            cmd.tick_check = 1'b1;
            state_next     = S_TICK;
          end
          OP_RESET: begin
            cmd.clear_all = 1'b1;
            state_next    = S_FIN;
          end
          default: state_next = S_FIN;
        endcase
      end
      S_LOAD: begin
        cmd.push_rom = 1'b1;
        if (status.rom_last) state_next = S_FIN;
      end
      S_TICK: begin
        cmd.tick_apply = 1'b1;
        state_next     = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/sfxseq_dp.sv @@
module sfxseq_dp
  import sfxseq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [1:0]          operation,
  input  logic [EFFECT_W-1:0] effect_id,
  input  logic [FREQ_W-1:0]   note_frequency,
  input  logic [LEN_W-1:0]    note_length,
  input  logic [TIME_W-1:0]   time_now,
  output logic                stop_tone,
  output logic                start_tone,
  output logic [FREQ_W-1:0]   tone_frequency,
  output logic [LEN_W-1:0]    tone_length,
  output logic [QCOUNT_W-1:0] queued_notes,
  output logic                playing,
  output logic                note_dropped
);

  localparam int unsigned HW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = HW + 1;

  // captured item
  op_t                 op_r;
  logic [EFFECT_W-1:0] effect_r;
  note_t               note_r;
  logic [TIME_W-1:0]   now_r;

  // queue and tone state
  note_t             mem [QUEUE_DEPTH];
  note_t             rd_note;
  logic [HW-1:0]     head;
  logic [CW-1:0]     count;
  logic              tone_on;
  logic [TIME_W-1:0] tone_start_time;
  logic [LEN_W-1:0]  active_length;
  logic [1:0]        rom_idx;

  // per-item result flags
  logic              stop_f, start_f, drop_f;
  note_t             started;
  logic              expire_r, go_on_r;

  logic [SW-1:0]     slot_sum;
  logic [HW-1:0]     slot;
  logic              full;
  logic              push;
  note_t             wdata;
  logic [HW-1:0]     head_inc;
  logic [TIME_W-1:0] elapsed;
  logic              expire;
  logic [CW+QCOUNT_W-1:0] count_ext;

  assign slot_sum = SW'(head) + SW'(count);
  assign slot     = (slot_sum >= SW'(QUEUE_DEPTH)) ? HW'(slot_sum - SW'(QUEUE_DEPTH))
                                                   : HW'(slot_sum);
  assign full     = (count >= CW'(QUEUE_DEPTH));
  assign push     = (cmd.push_rom || cmd.push_in) && !full;
  assign wdata    = cmd.push_rom ? effect_note(effect_r, rom_idx) : note_r;
  assign head_inc = (head == HW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign elapsed  = now_r - tone_start_time;
  assign expire   = tone_on && (elapsed >= TIME_W'(active_length));

  assign status.op           = op_r;
  assign status.effect_known = (effect_r < EFFECT_W'(NUM_EFFECTS));
  assign status.rom_last     = (rom_idx == effect_last_idx(effect_r));

  // note memory: one write port, registered read of the head entry
  always_ff @(posedge clk) begin
    if (push) mem[slot] <= wdata;
    rd_note <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= op_t'(operation);
      effect_r <= effect_id;
      note_r   <= '{freq: note_frequency, len: note_length};
      now_r    <= time_now;
      started  <= '0;
    end
    if (cmd.tick_check) begin
      expire_r <= expire;
      go_on_r  <= !tone_on || expire;
    end
    if (cmd.tick_apply && go_on_r && (count != '0)) begin
      started         <= rd_note;
      tone_start_time <= now_r;
      active_length   <= rd_note.len;
    end
    if (rst) begin
      tone_start_time <= '0;
      active_length   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      tone_on <= 1'b0;
      rom_idx <= '0;
      stop_f  <= 1'b0;
      start_f <= 1'b0;
      drop_f  <= 1'b0;
    end else begin
      if (cmd.capture) begin
        stop_f  <= 1'b0;
        start_f <= 1'b0;
        drop_f  <= 1'b0;
      end
      if (cmd.clear_all) begin
        head    <= '0;
        count   <= '0;
        tone_on <= 1'b0;
        stop_f  <= 1'b1;
        rom_idx <= '0;
      end
      if (push) count <= count + 1'b1;
      if (cmd.push_in && full) drop_f <= 1'b1;
      if (cmd.push_rom) rom_idx <= rom_idx + 1'b1;
      if (cmd.tick_apply) begin
        if (expire_r) begin
          tone_on <= 1'b0;
          stop_f  <= 1'b1;
        end
        if (go_on_r && (count != '0)) begin
          head    <= head_inc;
          count   <= count - 1'b1;
          tone_on <= 1'b1;
          start_f <= 1'b1;
        end
      end
    end
  end

  assign count_ext = {{QCOUNT_W{1'b0}}, count};

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      stop_tone      <= stop_f;
      start_tone     <= start_f;
      tone_frequency <= started.freq;
      tone_length    <= started.len;
      queued_notes   <= count_ext[QCOUNT_W-1:0];
      playing        <= tone_on;
      note_dropped   <= drop_f;
    end
  end

endmodule

@@ rtl/sound_effect_note_sequencer_unit.sv @@
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_ready   operation, effect_id, note_frequency,
//                                     note_length, time_now
// out      out  out_valid / out_ready stop_tone, start_tone, tone_frequency,
//                                     tone_length, queued_notes, playing,
//                                     note_dropped
//
// From input transfer to result valid an item passes DECODE, then TICK
// for a tick or LOAD per note of a known effect, then FIN, one at a time.
// Reset (rst, synchronous) empties the queue and silences the tone; the
// note memory is not cleared, only written entries are ever read.
// A result waiting on out_ready does not block the next input transfer;
// only the final load of a second result waits for the output register.
module sound_effect_note_sequencer_unit
  import sfxseq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic [EFFECT_W-1:0] effect_id,
  input  logic [FREQ_W-1:0]   note_frequency,
  input  logic [LEN_W-1:0]    note_length,
  input  logic [TIME_W-1:0]   time_now,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                stop_tone,
  output logic                start_tone,
  output logic [FREQ_W-1:0]   tone_frequency,
  output logic [LEN_W-1:0]    tone_length,
  output logic [QCOUNT_W-1:0] queued_notes,
  output logic                playing,
  output logic                note_dropped
);

  cmd_t    cmd;
  status_t status;

  // sequencing of decode, effect load, tick and result hand-off
  sfxseq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // note queue, tone timer and result register
  sfxseq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .operation      (operation),
    .effect_id      (effect_id),
    .note_frequency (note_frequency),
    .note_length    (note_length),
    .time_now       (time_now),
    .stop_tone      (stop_tone),
    .start_tone     (start_tone),
    .tone_frequency (tone_frequency),
    .tone_length    (tone_length),
    .queued_notes   (queued_notes),
    .playing        (playing),
    .note_dropped   (note_dropped)
  );

endmodule

@@ rtl/sfxseq_checker.sv @@
module sfxseq_checker
  import sfxseq_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic                stop_tone,
  input logic                start_tone,
  input logic [FREQ_W-1:0]   tone_frequency,
  input logic [LEN_W-1:0]    tone_length,
  input logic [QCOUNT_W-1:0] queued_notes,
  input logic                playing,
  input logic                note_dropped
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tone_frequency)
      && $stable(queued_notes) && $stable(start_tone))
    else $error("stalled result changed");

  a_start_plays: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_tone |-> playing)
    else $error("note started but tone not active");

  a_no_start_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !start_tone |-> tone_frequency == '0 && tone_length == '0)
    else $error("tone fields set without a start");

  a_drop_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && note_dropped |-> !stop_tone && !start_tone)
    else $error("dropped note with tone change");

endmodule

bind sound_effect_note_sequencer_unit sfxseq_checker u_chk (.*);
